### hw/rtl/hbl_pkg.sv
// ----------------------------------------------------------------------------
// hbl_pkg
// Shared types and constants for the Hamming-ball hash lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package hbl_pkg;

  localparam int unsigned SlotBitsDef  = 12;
  localparam int unsigned MaxItemsDef  = 1024;
  localparam int unsigned MaxProbesDef = 16;
  localparam int unsigned ReturnCapDef = 64;
  localparam int unsigned FirstStep    = 15;
  localparam int unsigned CodeW        = 64;
  localparam int unsigned ModDigits    = 4;

  typedef enum logic [1:0] {
    CFG_CODE_BYTES    = 2'd0,
    CFG_SEARCH_RADIUS = 2'd1,
    CFG_TABLE_MODULUS = 2'd2,
    CFG_MAX_RETURN    = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_POOL_FULL = 3'd1,
    ST_PROBE_LIM = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NONE      = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_SLOT,
    S_EMIT,
    S_LINK,
    S_NEXT,
    S_FINISH
  } state_e;

endpackage

`default_nettype wire

### hw/rtl/hbl_ram.sv
// ----------------------------------------------------------------------------
// hbl_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module hbl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### hw/rtl/hbl_mod.sv
// ----------------------------------------------------------------------------
// hbl_mod
// Iterative 64-bit modulo by a runtime modulus, four bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module hbl_mod #(
  parameter int unsigned SLOT_BITS = 12
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  output      logic                  done_o,
  input  wire logic [63:0]           value_i,
  input  wire logic [SLOT_BITS:0]    modulus_i,
  output      logic [SLOT_BITS-1:0]  rem_o
);
  import hbl_pkg::*;

  localparam int unsigned MW    = SLOT_BITS + 1;
  localparam int unsigned Steps = CodeW / ModDigits;
  localparam int unsigned CW    = $clog2(Steps);

  logic [MW-1:0]    r_q, r_d;
  logic [CodeW-1:0] val_q;
  logic [CW-1:0]    cnt_q;
  logic             run_q, done_q;

  always_comb begin
    r_d = r_q;
    for (int s = 0; s < ModDigits; s++) begin
      r_d = {r_d[MW-2:0], val_q[CodeW-1-s]};
      if (r_d >= modulus_i) begin
        r_d = r_d - modulus_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(Steps - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      r_q   <= '0;
      val_q <= value_i;
    end else if (run_q) begin
      r_q   <= r_d;
      val_q <= val_q << ModDigits;
    end
  end

  assign done_o = done_q;
  assign rem_o  = r_q[SLOT_BITS-1:0];

endmodule

`default_nettype wire

### hw/rtl/hamming_ball_hash_lookup.sv
// ----------------------------------------------------------------------------
// hamming_ball_hash_lookup
// Open-addressed code table with item chains; queries search a Hamming ball.
//
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------------
//  input    | start_i, busy_o        | kind_i, code_i
//  result   | result_valid_o (pulse) | item_number_o, status_o, last_o
//  config   | cfg_we_i               | cfg_idx_i, cfg_data_i
//
// Each probe runs the modulo unit on the candidate code and then reads the slot.
// An insert gives its result after at most MAX_PROBES probes, or without a probe
// when the pool is full; a query repeats the probe per candidate code and
// follows the item chain of each matching slot.
// After reset a clearing pass over all 2^SLOT_BITS slots holds busy_o high.
// Results cannot be stalled; one is shown per strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module hamming_ball_hash_lookup #(
  parameter int unsigned SLOT_BITS  = hbl_pkg::SlotBitsDef,
  parameter int unsigned MAX_ITEMS  = hbl_pkg::MaxItemsDef,
  parameter int unsigned MAX_PROBES = hbl_pkg::MaxProbesDef,
  parameter int unsigned RETURN_CAP = hbl_pkg::ReturnCapDef
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  output      logic                           busy_o,
  input  wire logic                           kind_i,
  input  wire logic [63:0]                    code_i,
  input  wire logic                           cfg_we_i,
  input  wire logic [1:0]                     cfg_idx_i,
  input  wire logic [12:0]                    cfg_data_i,
  output      logic                           result_valid_o,
  output      logic [$clog2(MAX_ITEMS+1)-1:0] item_number_o,
  output      logic [2:0]                     status_o,
  output      logic                           last_o
);
  import hbl_pkg::*;

  localparam int unsigned IW    = $clog2(MAX_ITEMS);
  localparam int unsigned NW    = $clog2(MAX_ITEMS + 1);
  localparam int unsigned SW    = 1 + CodeW + IW;
  localparam int unsigned MW    = SLOT_BITS + 1;
  localparam int unsigned PW    = $clog2(MAX_PROBES) + 1;
  localparam int unsigned Table = 1 << SLOT_BITS;

  // configuration
  logic [3:0]  cb_q;
  logic [1:0]  rad_q;
  logic [12:0] tm_q;
  logic [6:0]  mr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cb_q  <= 4'd8;
      rad_q <= 2'd1;
      tm_q  <= 13'd4093;
      mr_q  <= 7'd64;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_CODE_BYTES:    cb_q  <= cfg_data_i[3:0];
        CFG_SEARCH_RADIUS: rad_q <= cfg_data_i[1:0];
        CFG_TABLE_MODULUS: tm_q  <= cfg_data_i;
        CFG_MAX_RETURN:    mr_q  <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  logic [6:0]       bits;
  logic [CodeW-1:0] cmask;
  logic [MW-1:0]    modulus;
  logic [6:0]       cap;

  always_comb begin
    if (cb_q == 4'd0) begin
      bits = 7'd8;
    end else if (cb_q > 4'd8) begin
      bits = 7'd64;
    end else begin
      bits = {cb_q[3:0], 3'b000};
    end
    for (int k = 0; k < CodeW; k++) begin
      cmask[k] = (7'(k) < bits);
    end
    if (tm_q < 13'd2) begin
      modulus = MW'(2);
    end else if (32'(tm_q) > Table) begin
      modulus = MW'(Table);
    end else begin
      modulus = MW'(tm_q);
    end
    if (mr_q == 7'd0) begin
      cap = 7'd1;
    end else if (32'(mr_q) > RETURN_CAP) begin
      cap = 7'(RETURN_CAP);
    end else begin
      cap = mr_q;
    end
  end

  // control state
  state_e           state_q, state_d;
  logic [SLOT_BITS:0] clr_q, clr_d;
  logic             kind_q, kind_d;
  logic [CodeW-1:0] code_q, code_d, cand_q, cand_d, step_q, step_d;
  logic [PW-1:0]    pn_q, pn_d;
  logic [1:0]       lvl_q, lvl_d;
  logic [5:0]       a_q, a_d, b_q, b_d, c_q, c_d;
  logic [6:0]       cnt_q, cnt_d;
  logic [NW-1:0]    stored_q, stored_d;
  logic [IW-1:0]    idx_q, idx_d;
  logic             pv_q, pv_d;
  logic [NW-1:0]    pitem_q, pitem_d;
  logic             rv_q, rv_d, rl_q, rl_d;
  logic [NW-1:0]    ritem_q, ritem_d;
  logic [2:0]       rst_q, rst_d;

  logic             mstart, mdone;
  logic [CodeW-1:0] mval;
  logic [SLOT_BITS-1:0] mrem;

  logic             s_we, c_we;
  logic [SLOT_BITS-1:0] s_waddr;
  logic [SW-1:0]    s_wdata, s_rdata;
  logic [NW-1:0]    c_wdata, c_rdata;

  logic             s_valid;
  logic [CodeW-1:0] s_code;
  logic [IW-1:0]    s_head;

  assign s_valid = s_rdata[SW-1];
  assign s_code  = s_rdata[SW-2 -: CodeW];
  assign s_head  = s_rdata[IW-1:0];

  // next candidate in the Hamming ball
  logic       adv_ok;
  logic [1:0] nl;
  logic [5:0] na, nb, nc;
  logic [CodeW-1:0] flip;

  always_comb begin
    logic nxt;
    nxt    = 1'b0;
    adv_ok = 1'b1;
    nl = lvl_q;
    na = a_q;
    nb = b_q;
    nc = c_q;
    case (lvl_q)
      2'd1: begin
        if ({2'b0, a_q} + 8'd1 < {1'b0, bits}) begin
          na = a_q + 6'd1;
        end else begin
          nxt = 1'b1;
        end
      end
      2'd2: begin
        if ({2'b0, b_q} + 8'd1 < {1'b0, bits}) begin
          nb = b_q + 6'd1;
        end else if ({2'b0, a_q} + 8'd2 < {1'b0, bits}) begin
          na = a_q + 6'd1;
          nb = a_q + 6'd2;
        end else begin
          nxt = 1'b1;
        end
      end
      2'd3: begin
        if ({2'b0, c_q} + 8'd1 < {1'b0, bits}) begin
          nc = c_q + 6'd1;
        end else if ({2'b0, b_q} + 8'd2 < {1'b0, bits}) begin
          nb = b_q + 6'd1;
          nc = b_q + 6'd2;
        end else if ({2'b0, a_q} + 8'd3 < {1'b0, bits}) begin
          na = a_q + 6'd1;
          nb = a_q + 6'd2;
          nc = a_q + 6'd3;
        end else begin
          nxt = 1'b1;
        end
      end
      default: nxt = 1'b1;
    endcase
    if (nxt) begin
      if (lvl_q < rad_q) begin
        nl = lvl_q + 2'd1;
        na = 6'd0;
        nb = 6'd1;
        nc = 6'd2;
      end else begin
        adv_ok = 1'b0;
      end
    end
    for (int k = 0; k < CodeW; k++) begin
      flip[k] = (nl >= 2'd1 && 6'(k) == na) ^ (nl >= 2'd2 && 6'(k) == nb)
              ^ (nl >= 2'd3 && 6'(k) == nc);
    end
  end

  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    kind_d   = kind_q;
    code_d   = code_q;
    cand_d   = cand_q;
    step_d   = step_q;
    pn_d     = pn_q;
    lvl_d    = lvl_q;
    a_d      = a_q;
    b_d      = b_q;
    c_d      = c_q;
    cnt_d    = cnt_q;
    stored_d = stored_q;
    idx_d    = idx_q;
    pv_d     = pv_q;
    pitem_d  = pitem_q;
    rv_d     = 1'b0;
    rl_d     = 1'b0;
    ritem_d  = ritem_q;
    rst_d    = rst_q;
    mstart   = 1'b0;
    mval     = cand_q;
    s_we     = 1'b0;
    s_waddr  = mrem;
    s_wdata  = {1'b1, cand_q, stored_q[IW-1:0]};
    c_we     = 1'b0;
    c_wdata  = s_valid ? ({1'b0, s_head} + NW'(1)) : '0;

    case (state_q)
      S_CLEAR: begin
        s_we    = 1'b1;
        s_waddr = clr_q[SLOT_BITS-1:0];
        s_wdata = '0;
        clr_d   = clr_q + 1'b1;
        if (clr_q == (SLOT_BITS+1)'(Table - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          kind_d = kind_i;
          code_d = code_i & cmask;
          cand_d = code_i & cmask;
          lvl_d  = 2'd0;
          cnt_d  = '0;
          pv_d   = 1'b0;
          if (!kind_i && 32'(stored_q) >= MAX_ITEMS) begin
            rv_d    = 1'b1;
            rl_d    = 1'b1;
            ritem_d = '0;
            rst_d   = ST_POOL_FULL;
          end else begin
            pn_d    = '0;
            step_d  = CodeW'(FirstStep);
            mval    = code_i & cmask;
            mstart  = 1'b1;
            state_d = S_MOD;
          end
        end
      end
      S_MOD: begin
        if (mdone) begin
          state_d = S_SLOT;
        end
      end
      S_SLOT: begin
        if (!s_valid || s_code == cand_q) begin
          if (!kind_q) begin
            s_we     = 1'b1;
            c_we     = 1'b1;
            stored_d = stored_q + 1'b1;
            rv_d     = 1'b1;
            rl_d     = 1'b1;
            ritem_d  = stored_q + 1'b1;
            rst_d    = ST_INSERTED;
            state_d  = S_IDLE;
          end else if (s_valid) begin
            idx_d   = s_head;
            state_d = S_EMIT;
          end else begin
            state_d = S_NEXT;
          end
        end else if (pn_q + 1'b1 == PW'(MAX_PROBES)) begin
          if (!kind_q) begin
            rv_d    = 1'b1;
            rl_d    = 1'b1;
            ritem_d = '0;
            rst_d   = ST_PROBE_LIM;
            state_d = S_IDLE;
          end else begin
            state_d = S_NEXT;
          end
        end else begin
          pn_d    = pn_q + 1'b1;
          mval    = cand_q + step_q;
          mstart  = 1'b1;
          step_d  = step_q << 1;
          state_d = S_MOD;
        end
      end
      S_EMIT: begin
        if (pv_q) begin
          rv_d    = 1'b1;
          ritem_d = pitem_q;
          rst_d   = ST_FOUND;
        end
        pv_d    = 1'b1;
        pitem_d = {1'b0, idx_q} + NW'(1);
        cnt_d   = cnt_q + 7'd1;
        state_d = S_LINK;
      end
      S_LINK: begin
        if (cnt_q < cap && c_rdata != '0) begin
          idx_d   = IW'(c_rdata - NW'(1));
          state_d = S_EMIT;
        end else begin
          state_d = S_NEXT;
        end
      end
      S_NEXT: begin
        if (cnt_q >= cap || !adv_ok) begin
          state_d = S_FINISH;
        end else begin
          lvl_d   = nl;
          a_d     = na;
          b_d     = nb;
          c_d     = nc;
          cand_d  = code_q ^ flip;
          mval    = code_q ^ flip;
          pn_d    = '0;
          step_d  = CodeW'(FirstStep);
          mstart  = 1'b1;
          state_d = S_MOD;
        end
      end
      S_FINISH: begin
        rv_d    = 1'b1;
        rl_d    = 1'b1;
        ritem_d = pv_q ? pitem_q : '0;
        rst_d   = pv_q ? ST_FOUND : ST_NONE;
        pv_d    = 1'b0;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      clr_q    <= '0;
      stored_q <= '0;
      pv_q     <= 1'b0;
      rv_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      stored_q <= stored_d;
      pv_q     <= pv_d;
      rv_q     <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    code_q  <= code_d;
    cand_q  <= cand_d;
    step_q  <= step_d;
    pn_q    <= pn_d;
    lvl_q   <= lvl_d;
    a_q     <= a_d;
    b_q     <= b_d;
    c_q     <= c_d;
    cnt_q   <= cnt_d;
    idx_q   <= idx_d;
    pitem_q <= pitem_d;
    ritem_q <= ritem_d;
    rst_q   <= rst_d;
    rl_q    <= rl_d;
  end

  hbl_mod #(
    .SLOT_BITS(SLOT_BITS)
  ) u_mod (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mstart),
    .done_o   (mdone),
    .value_i  (mval),
    .modulus_i(modulus),
    .rem_o    (mrem)
  );

  hbl_ram #(
    .WIDTH(SW),
    .DEPTH(Table)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (s_we),
    .waddr_i(s_waddr),
    .wdata_i(s_wdata),
    .raddr_i(mrem),
    .rdata_o(s_rdata)
  );

  hbl_ram #(
    .WIDTH(NW),
    .DEPTH(MAX_ITEMS)
  ) u_chain_ram (
    .clk_i  (clk_i),
    .we_i   (c_we),
    .waddr_i(stored_q[IW-1:0]),
    .wdata_i(c_wdata),
    .raddr_i(idx_q),
    .rdata_o(c_rdata)
  );

  assign busy_o         = (state_q != S_IDLE);
  assign result_valid_o = rv_q;
  assign item_number_o  = ritem_q;
  assign status_o       = rst_q;
  assign last_o         = rl_q;

`ifndef SYNTHESIS
  a_final_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_o |-> !busy_o)
    else $error("final result while busy");

  a_mid_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |-> busy_o && status_o == ST_FOUND)
    else $error("partial result outside a query");

  a_slot_after_mod : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SLOT |-> $past(state_q) == S_MOD && $past(mdone))
    else $error("slot checked without a fresh read");

  a_stored_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(stored_q) <= MAX_ITEMS)
    else $error("stored count overflow");
`endif

endmodule

`default_nettype wire
